// ----- hw/rtl/gnrl_pkg.sv -----
package gnrl_pkg;

	localparam int MaxRecords = 1024;
	localparam int IdxW = $clog2(MaxRecords);
	localparam int CntW = $clog2(MaxRecords + 1);
	localparam int RecW = 320;
	localparam int DistW = 40;
	localparam int IdxOutW = 10;

	localparam logic [30:0] StateWindowRst = 31'd655360;
	localparam logic [30:0] InputWindowRst = 31'd655360;
	localparam logic [39:0] DistanceLimitRst = 40'd65536000000;

	localparam logic [1:0] RegStateWindow = 2'd0;
	localparam logic [1:0] RegInputWindow = 2'd1;
	localparam logic [1:0] RegDistanceLimit = 2'd2;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusFull = 2'd1;
	localparam logic [1:0] StatusEmpty = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [31:0] arm_cmd;
		logic signed [31:0] base_cmd;
		logic [9:0] chosen_index;
		logic matched;
		logic [1:0] status;
	} result_t;

	function automatic logic [32:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

endpackage

// ----- hw/rtl/gnrl_store.sv -----
module gnrl_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [gnrl_pkg::IdxW-1:0]  waddr,
	input  logic [gnrl_pkg::RecW-1:0]  wdata,
	input  logic [gnrl_pkg::IdxW-1:0]  raddr,
	output logic [gnrl_pkg::RecW-1:0]  rdata
);
	import gnrl_pkg::*;

	logic [RecW-1:0] mem [MaxRecords];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/gnrl_eval.sv -----
module gnrl_eval (
	input  logic [gnrl_pkg::RecW-1:0] rec,
	input  logic [gnrl_pkg::RecW-1:0] hist,
	input  logic signed [31:0]        pitch,
	input  logic signed [31:0]        yaw,
	input  logic [30:0]               state_window,
	input  logic [30:0]               input_window,
	output logic                      pass,
	output logic [gnrl_pkg::DistW-1:0] rec_dist
);
	import gnrl_pkg::*;

	logic [32:0] dp;
	logic [32:0] dy;

	always_comb begin
		pass = 1'b1;
		for (int s = 2; s < 6; s++) begin
			if (abs_diff(rec[s*32 +: 32], hist[s*32 +: 32]) > {2'b00, state_window}) begin
				pass = 1'b0;
			end
		end
		for (int s = 8; s < 10; s++) begin
			if (abs_diff(rec[s*32 +: 32], hist[s*32 +: 32]) > {2'b00, input_window}) begin
				pass = 1'b0;
			end
		end
		dp = abs_diff(rec[31:0], pitch);
		dy = abs_diff(rec[63:32], yaw);
		rec_dist = DistW'(dp) + DistW'(dy);
	end

endmodule

// ----- hw/rtl/gated_nearest_record_lookup.sv -----
// Record table search. A load request (kind 0) appends a ten-word record and
// returns a result, with status full and no append once the table is full; a
// query (kind 1) scans every stored record from the record memory (one write
// port, one registered read port), one record per cycle, then fetches the
// winner, or on an empty table returns status empty. Results sit in an output
// register; the next request is taken the cycle after the result leaves.
module gated_nearest_record_lookup (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [319:0] s_tdata,  // cur_pitch, cur_yaw, pitch_back1, yaw_back1, pitch_back2,
	                               // yaw_back2, arm_now, base_now, arm_back1, base_back1
	input  logic         s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,  // arm_cmd, base_cmd, chosen_index, matched, status, zero pad
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	import gnrl_pkg::*;

	state_t state_q, state_d;
	logic [30:0] state_window_q, input_window_q;
	logic [39:0] distance_limit_q;
	logic [CntW-1:0] count_q;
	logic [RecW-1:0] hist_q;
	logic [CntW-1:0] scan_q;
	logic            rvalid_s1;
	logic [IdxW-1:0] ridx_s1;
	logic [DistW-1:0] best_q;
	logic [IdxW-1:0] best_idx_q;
	logic            found_q;
	logic signed [31:0] pitch_q, yaw_q;
	result_t         res_q;
	logic            out_valid_q;

	logic            we;
	logic [IdxW-1:0] raddr;
	logic [RecW-1:0] rdata;
	logic            pass;
	logic [DistW-1:0] rec_dist;
	logic            in_acc;
	logic [1:0]      reg_idx;

	assign pready = 1'b1;
	// 8-byte register spacing
	assign reg_idx = paddr[4:3];
	always_comb begin
		case (paddr)
			{RegStateWindow, 3'b000}:   prdata = {33'd0, state_window_q};
			{RegInputWindow, 3'b000}:   prdata = {33'd0, input_window_q};
			{RegDistanceLimit, 3'b000}: prdata = {24'd0, distance_limit_q};
			default:                    prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_window_q   <= StateWindowRst;
			input_window_q   <= InputWindowRst;
			distance_limit_q <= DistanceLimitRst;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2:0] == 3'd0) begin
				case (reg_idx)
					RegStateWindow:   state_window_q <= pwdata[30:0];
					RegInputWindow:   input_window_q <= pwdata[30:0];
					RegDistanceLimit: distance_limit_q <= pwdata[39:0];
					default: ;
				endcase
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, res_q.status, res_q.matched, res_q.chosen_index,
		res_q.base_cmd, res_q.arm_cmd};

	assign we = in_acc && !s_tuser && (count_q < CntW'(MaxRecords));
	assign raddr = (state_q == ST_SCAN) ? scan_q[IdxW-1:0] : best_idx_q;

	gnrl_store u_store (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[IdxW-1:0]),
		.wdata(s_tdata),
		.raddr(we ? count_q[IdxW-1:0] : raddr),
		.rdata(rdata)
	);

	gnrl_eval u_eval (
		.rec         (rdata),
		.hist        (hist_q),
		.pitch       (pitch_q),
		.yaw         (yaw_q),
		.state_window(state_window_q),
		.input_window(input_window_q),
		.pass        (pass),
		.rec_dist    (rec_dist)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc && s_tuser && count_q != '0) state_d = ST_SCAN;
			ST_SCAN:  if (scan_q == count_q - 1'b1) state_d = ST_FETCH;
			ST_FETCH: if (!rvalid_s1) state_d = ST_WAIT;
			ST_WAIT:  state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			hist_q      <= '0;
			scan_q      <= '0;
			rvalid_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= (state_q == ST_SCAN);
			ridx_s1   <= scan_q[IdxW-1:0];
			if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			if (in_acc) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				best_q  <= distance_limit_q;
				best_idx_q <= '0;
				pitch_q <= s_tdata[31:0];
				yaw_q   <= s_tdata[63:32];
				if (!s_tuser) begin
					res_q <= '{arm_cmd: '0, base_cmd: '0, chosen_index: '0, matched: 1'b0,
						status: (count_q < CntW'(MaxRecords)) ? StatusOk : StatusFull};
					out_valid_q <= 1'b1;
					if (count_q < CntW'(MaxRecords)) count_q <= count_q + 1'b1;
				end else if (count_q == '0) begin
					res_q <= '{arm_cmd: '0, base_cmd: '0, chosen_index: '0, matched: 1'b0,
						status: StatusEmpty};
					out_valid_q <= 1'b1;
				end
			end
			if (state_q == ST_SCAN) scan_q <= scan_q + 1'b1;
			if (rvalid_s1 && pass && rec_dist < best_q) begin
				best_q     <= rec_dist;
				best_idx_q <= ridx_s1;
				found_q    <= 1'b1;
			end
			if (state_q == ST_DONE) begin
				res_q <= '{arm_cmd: rdata[223:192], base_cmd: rdata[255:224],
					chosen_index: IdxOutW'(best_idx_q), matched: found_q, status: StatusOk};
				out_valid_q <= 1'b1;
				hist_q <= {hist_q[255:192], rdata[255:192],
					hist_q[127:64], hist_q[63:0], yaw_q, pitch_q};
			end
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready) else $error("accept while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxRecords)) else $error("count overflow");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> out_valid_q) else $error("lost result");
`endif

endmodule
